@@ rtl/dmxcf_pkg.sv @@
// Shared types and constants for the DMX channel crossfade engine.
// No dependencies.
`default_nettype none
package dmxcf_pkg;
    localparam int CHANNELS = 32;
    localparam int CH_W = $clog2(CHANNELS);
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam logic [15:0] RAMP_MS_RST = 16'd500;
    localparam logic [15:0] SEND_IVL_RST = 16'd25;
    localparam logic CFG_RAMP_MS = 1'b0;
    localparam logic CFG_SEND_IVL = 1'b1;
    localparam logic OP_LEVEL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_COPY   = 8'b00000010,
        S_STAGE  = 8'b00000100,
        S_JUMP   = 8'b00001000,
        S_MUL    = 8'b00010000,
        S_DIV    = 8'b00100000,
        S_WRITE  = 8'b01000000,
        S_FRAME  = 8'b10000000
    } state_t;
endpackage
`default_nettype wire

@@ rtl/dmx_channel_crossfade_engine.sv @@
// Top level of the DMX channel crossfade engine: level memories, ramp sequencer, frame output.
// Depends on dmxcf_pkg and dmxcf_div.
//
// Level requests leave the engine idle unless last; a committing request walks all 32 channels
// for the copy, then the staged range for the staged overwrite, and without ramp all 32 again
// and a frame. A ramp tick walks the channels through one shared multiplier and a serial
// divider, then, once the send interval is up, a frame streams 33 bytes at one per cycle.
// Busy stays high meanwhile; results carry a strobe and cannot be stalled by the receiver.
`default_nettype none
module dmx_channel_crossfade_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        op,
    input  wire logic [9:0]  start_channel,
    input  wire logic [7:0]  level,
    input  wire logic        last,
    input  wire logic        ramp,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             strobe,
    output logic [5:0]       slot,
    output logic [7:0]       data,
    output logic             frame_end
);
    import dmxcf_pkg::*;

    // Memories: current, start, target, staged
    logic [7:0] cur_mem [CHANNELS];
    logic [7:0] sta_mem [CHANNELS];
    logic [7:0] tgt_mem [CHANNELS];
    logic [7:0] stg_mem [CHANNELS];
    logic [CHANNELS-1:0] cur_vld_reg, sta_vld_reg, tgt_vld_reg;

    logic [7:0] cur_rd_reg, sta_rd_reg, tgt_rd_reg, stg_rd_reg;

    logic [15:0] ramp_ms_reg, send_ivl_reg;
    logic [31:0] now_reg, begin_reg, lastf_reg;
    logic        ramping_reg;
    logic [9:0]  base_reg;
    logic [CNT_W-1:0] count_reg;

    state_t      st_reg;
    logic [CNT_W:0] idx_reg;
    logic        rd_ok_reg;
    logic        ramp_do_reg;
    logic [CH_W-1:0] first_reg;
    logic [CNT_W-1:0] bcnt_reg;
    logic [31:0] elapsed_reg;
    logic [23:0] prod_reg;
    logic        up_reg;
    logic [7:0]  a_reg;

    logic        div_go;
    logic        div_done;
    logic [23:0] div_q;

    dmxcf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (prod_reg),
        .divisor  (ramp_ms_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    logic accept;
    assign accept    = start && !busy;
    assign busy      = (st_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    logic [CH_W-1:0] idx;
    assign idx = idx_reg[CH_W-1:0];

    logic [31:0] now_inc;
    assign now_inc = now_reg + 32'd1;

    // commit decode
    logic [9:0]  base_eff;
    logic [9:0]  first_w;
    logic [CNT_W-1:0] cnt_new;
    logic [10:0] span;
    logic [CNT_W-1:0] cnt_clip;
    logic        commit_ok;
    always_comb
    begin
        base_eff = (count_reg == '0) ? start_channel : base_reg;
        cnt_new  = (count_reg < CNT_W'(CHANNELS)) ? count_reg + 1'b1 : count_reg;
        if (base_eff == 10'd0)
            first_w = 10'd0;
        else
            first_w = base_eff - 10'd1;
        commit_ok = (first_w < 10'(CHANNELS));
        span = 11'(first_w) + 11'(cnt_new);
        if (span > 11'(CHANNELS))
            cnt_clip = CNT_W'(11'(CHANNELS) - 11'(first_w));
        else
            cnt_clip = cnt_new;
    end

    // memory reads for the channel at idx
    logic        cur_v, sta_v, tgt_v;
    assign cur_v = cur_vld_reg[idx];
    assign sta_v = sta_vld_reg[idx];
    assign tgt_v = tgt_vld_reg[idx];

    always_ff @(posedge clk)
    begin
        cur_rd_reg <= cur_mem[idx];
        sta_rd_reg <= sta_mem[idx];
        tgt_rd_reg <= tgt_mem[idx];
        stg_rd_reg <= stg_mem[CH_W'(idx - first_reg)];
    end

    logic cur_v_q, sta_v_q, tgt_v_q;
    always_ff @(posedge clk)
    begin
        cur_v_q <= cur_v;
        sta_v_q <= sta_v;
        tgt_v_q <= tgt_v;
    end

    logic [7:0] cur_q, sta_q, tgt_q;
    assign cur_q = cur_v_q ? cur_rd_reg : 8'd0;
    assign sta_q = sta_v_q ? sta_rd_reg : 8'd0;
    assign tgt_q = tgt_v_q ? tgt_rd_reg : 8'd0;

    logic [7:0] diff;
    assign diff = (tgt_q >= sta_q) ? tgt_q - sta_q : sta_q - tgt_q;

    logic [7:0] interp;
    assign interp = up_reg ? a_reg + div_q[7:0] : a_reg - div_q[7:0];

    logic last_idx;
    assign last_idx = (idx_reg == (CNT_W+1)'(CHANNELS - 1));

    logic in_stage;
    assign in_stage = (idx_reg >= (CNT_W+1)'(first_reg))
        && (idx_reg < (CNT_W+1)'(first_reg) + (CNT_W+1)'(bcnt_reg));

    // product registered on the last multiply cycle, divider is started in the following cycle
    assign div_go = (st_reg == S_DIV) && rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (accept && op == OP_LEVEL && count_reg < CNT_W'(CHANNELS))
            stg_mem[count_reg[CH_W-1:0]] <= level;
        if (st_reg == S_COPY && rd_ok_reg)
        begin
            sta_mem[CH_W'(idx_reg - 1'b1)] <= cur_q;
            tgt_mem[CH_W'(idx_reg - 1'b1)] <= cur_q;
        end
        if (st_reg == S_STAGE && rd_ok_reg)
            tgt_mem[CH_W'(idx_reg - 1'b1)] <= stg_rd_reg;
        if (st_reg == S_JUMP && rd_ok_reg)
            cur_mem[CH_W'(idx_reg - 1'b1)] <= tgt_q;
        if (st_reg == S_WRITE)
            cur_mem[idx] <= interp;
        if (st_reg == S_MUL && rd_ok_reg)
        begin
            a_reg    <= sta_q;
            up_reg   <= (tgt_q >= sta_q);
            prod_reg <= 24'(diff) * 24'(elapsed_reg[15:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            idx_reg      <= '0;
            rd_ok_reg    <= 1'b0;
            ramp_ms_reg  <= RAMP_MS_RST;
            send_ivl_reg <= SEND_IVL_RST;
            now_reg      <= '0;
            begin_reg    <= '0;
            lastf_reg    <= '0;
            ramping_reg  <= 1'b0;
            base_reg     <= '0;
            count_reg    <= '0;
            ramp_do_reg  <= 1'b0;
            first_reg    <= '0;
            bcnt_reg     <= '0;
            elapsed_reg  <= '0;
            cur_vld_reg  <= '0;
            sta_vld_reg  <= '0;
            tgt_vld_reg  <= '0;
            strobe       <= 1'b0;
            slot         <= '0;
            data         <= '0;
            frame_end    <= 1'b0;
        end
        else
        begin
            strobe    <= 1'b0;
            frame_end <= 1'b0;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_RAMP_MS)
                    ramp_ms_reg <= cfg_data;
                else
                    send_ivl_reg <= cfg_data;
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    idx_reg   <= '0;
                    rd_ok_reg <= 1'b0;
                    if (accept)
                    begin
                        if (op == OP_TICK)
                        begin
                            now_reg <= now_inc;
                            if (ramping_reg)
                            begin
                                elapsed_reg <= now_inc - begin_reg;
                                if (now_inc - begin_reg >= {16'd0, ramp_ms_reg})
                                begin
                                    ramping_reg <= 1'b0;
                                    st_reg      <= S_JUMP;
                                end
                                else
                                    st_reg <= S_MUL;
                            end
                        end
                        else
                        begin
                            if (count_reg == '0)
                                base_reg <= start_channel;
                            count_reg <= last ? '0 : cnt_new;
                            if (last && commit_ok)
                            begin
                                first_reg   <= CH_W'(first_w);
                                bcnt_reg    <= cnt_clip;
                                ramp_do_reg <= ramp;
                                st_reg      <= S_COPY;
                            end
                        end
                    end
                end
                S_COPY:
                begin
                    if (rd_ok_reg)
                    begin
                        sta_vld_reg[CH_W'(idx_reg - 1'b1)] <= 1'b1;
                        tgt_vld_reg[CH_W'(idx_reg - 1'b1)] <= 1'b1;
                    end
                    if (idx_reg == (CNT_W+1)'(CHANNELS))
                    begin
                        idx_reg   <= (CNT_W+1)'(first_reg);
                        rd_ok_reg <= 1'b0;
                        st_reg    <= S_STAGE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        rd_ok_reg <= 1'b1;
                    end
                end
                S_STAGE:
                begin
                    if (!in_stage)
                    begin
                        rd_ok_reg <= 1'b0;
                        idx_reg   <= '0;
                        if (ramp_do_reg)
                        begin
                            begin_reg   <= now_reg;
                            ramping_reg <= 1'b1;
                            st_reg      <= S_IDLE;
                        end
                        else
                        begin
                            ramping_reg <= 1'b0;
                            st_reg      <= S_JUMP;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        rd_ok_reg <= 1'b1;
                    end
                end
                S_JUMP:
                begin
                    if (rd_ok_reg)
                        cur_vld_reg[CH_W'(idx_reg - 1'b1)] <= 1'b1;
                    if (idx_reg == (CNT_W+1)'(CHANNELS))
                    begin
                        idx_reg   <= '0;
                        rd_ok_reg <= 1'b0;
                        lastf_reg <= now_reg;
                        st_reg    <= S_FRAME;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        rd_ok_reg <= 1'b1;
                    end
                end
                S_MUL:
                begin
                    rd_ok_reg <= 1'b1;
                    if (rd_ok_reg)
                        st_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rd_ok_reg <= 1'b0;
                    if (div_done)
                        st_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    cur_vld_reg[idx] <= 1'b1;
                    if (last_idx)
                    begin
                        idx_reg <= '0;
                        if (now_reg - lastf_reg >= {16'd0, send_ivl_reg})
                        begin
                            lastf_reg <= now_reg;
                            st_reg    <= S_FRAME;
                        end
                        else
                            st_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        st_reg  <= S_MUL;
                    end
                end
                S_FRAME:
                begin
                    // idx 0: start code; channel k is read at idx k-1, then passes the read register and data
                    idx_reg   <= idx_reg + 1'b1;
                    rd_ok_reg <= 1'b1;
                    if (!rd_ok_reg)
                    begin
                        strobe <= 1'b1;
                        slot   <= '0;
                        data   <= '0;
                    end
                    else
                    begin
                        strobe <= 1'b1;
                        slot   <= 6'(idx_reg);
                        data   <= cur_q;
                        if (idx_reg == (CNT_W+1)'(CHANNELS))
                        begin
                            frame_end <= 1'b1;
                            rd_ok_reg <= 1'b0;
                            idx_reg   <= '0;
                            st_reg    <= S_IDLE;
                        end
                    end
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/dmxcf_div.sv @@
// Iterative restoring divider, 24-bit dividend by 16-bit divisor, one bit a cycle.
// Depends on dmxcf_pkg.
`default_nettype none
module dmxcf_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [23:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [23:0]      quotient
);
    import dmxcf_pkg::*;

    logic [16:0] rem_reg, rem_next;
    logic [23:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], q_reg[23]};
        if (go)
        begin
            rem_next = '0;
            q_next   = dividend;
            cnt_next = 5'd23;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            q_next = {q_reg[22:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next  = trial - {1'b0, divisor};
                q_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            if (cnt_reg == 5'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            cnt_next = cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

@@ dv/dmx_channel_crossfade_engine_tb.sv @@
// Self-checking testbench for dmx_channel_crossfade_engine: batches, ramp ticks and frames
// are predicted cycle-free in the bench and compared byte by byte. Depends on dmxcf_pkg
// and the engine RTL.
module dmx_channel_crossfade_engine_tb;
    import dmxcf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 1200;

    typedef struct {
        logic       op;
        logic [9:0] start_channel;
        logic [7:0] level;
        logic       last;
        logic       ramp;
    } dmx_req_t;

    typedef struct {
        logic [5:0] slot;
        logic [7:0] data;
        logic       frame_end;
    } frame_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic op = OP_LEVEL;
    logic [9:0] start_channel = '0;
    logic [7:0] level = '0;
    logic last = 1'b0;
    logic ramp = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_index = CFG_RAMP_MS;
    logic [15:0] cfg_data = '0;
    logic busy, cfg_ready, strobe, frame_end;
    logic [5:0] slot;
    logic [7:0] data;

    dmx_channel_crossfade_engine i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .start_channel(start_channel), .level(level), .last(last), .ramp(ramp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .strobe(strobe), .slot(slot), .data(data),
        .frame_end(frame_end)
    );

    // predicted engine state
    logic [15:0] m_ramp_ms = RAMP_MS_RST;
    logic [15:0] m_send_ivl = SEND_IVL_RST;
    logic [31:0] m_now, m_ramp_begin, m_last_frame;
    logic        m_ramping;
    logic [7:0]  m_cur [CHANNELS];
    logic [7:0]  m_from [CHANNELS];
    logic [7:0]  m_to [CHANNELS];
    logic [7:0]  m_staged [CHANNELS];
    int          m_base, m_count;

    dmx_req_t    pending_q[$];
    frame_byte_t frame_bytes_q[$];
    dmx_req_t    cur_req;
    bit          no_idle = 0;
    int          errors = 0;
    int          n_requests = 0;
    int          n_bytes = 0;
    int          n_frames = 0;
    int          idle_cycles = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void push_frame();
        frame_byte_t b;
        b.slot = 6'd0; b.data = 8'd0; b.frame_end = 1'b0;
        frame_bytes_q.push_back(b);
        for (int k = 0; k < CHANNELS; k++)
        begin
            b.slot = 6'(k + 1);
            b.data = m_cur[k];
            b.frame_end = (k == CHANNELS - 1);
            frame_bytes_q.push_back(b);
        end
        m_last_frame = m_now;
    endfunction

    function automatic void fade_tick();
        logic [31:0] elapsed;
        logic [63:0] delta;
        m_now = m_now + 32'd1;
        if (!m_ramping)
            return;
        elapsed = m_now - m_ramp_begin;
        if (elapsed >= {16'd0, m_ramp_ms})
        begin
            m_cur = m_to;
            m_ramping = 1'b0;
            push_frame();
            return;
        end
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (m_to[i] >= m_from[i])
            begin
                delta = (64'(m_to[i] - m_from[i]) * elapsed) / m_ramp_ms;
                m_cur[i] = m_from[i] + 8'(delta);
            end
            else
            begin
                delta = (64'(m_from[i] - m_to[i]) * elapsed) / m_ramp_ms;
                m_cur[i] = m_from[i] - 8'(delta);
            end
        end
        if (m_now - m_last_frame >= {16'd0, m_send_ivl})
            push_frame();
    endfunction

    function automatic void commit_levels(logic do_ramp);
        int first_ch, cnt;
        first_ch = (m_base < 1) ? 0 : m_base - 1;
        cnt = m_count;
        m_count = 0;
        if (first_ch >= CHANNELS || cnt == 0)
            return;
        if (first_ch + cnt > CHANNELS)
            cnt = CHANNELS - first_ch;
        m_from = m_cur;
        m_to = m_cur;
        for (int i = 0; i < cnt; i++)
            m_to[first_ch + i] = m_staged[i];
        if (!do_ramp)
        begin
            m_cur = m_to;
            m_ramping = 1'b0;
            push_frame();
        end
        else
        begin
            m_ramp_begin = m_now;
            m_ramping = 1'b1;
        end
    endfunction

    function automatic void predict_request(dmx_req_t r);
        if (r.op == OP_TICK)
        begin
            fade_tick();
            return;
        end
        if (m_count == 0)
            m_base = r.start_channel;
        if (m_count < CHANNELS)
        begin
            m_staged[m_count] = r.level;
            m_count++;
        end
        if (r.last)
            commit_levels(r.ramp);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_request(cur_req);
                n_requests++;
            end
            if (!start || !busy)
            begin
                if (pending_q.size() > 0 && (no_idle || $urandom_range(99) >= 32))
                begin
                    cur_req = pending_q.pop_front();
                    start <= 1'b1;
                    op <= cur_req.op;
                    start_channel <= cur_req.start_channel;
                    level <= cur_req.level;
                    last <= cur_req.last;
                    ramp <= cur_req.ramp;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        frame_byte_t e;
        if (rst_n && strobe)
        begin
            n_bytes++;
            if (frame_bytes_q.size() == 0)
            begin
                $error("unexpected byte: slot %0d data %0h", slot, data);
                errors++;
            end
            else
            begin
                e = frame_bytes_q.pop_front();
                if (e.frame_end)
                    n_frames++;
                if (slot !== e.slot)
                begin
                    $error("slot: expected %0d, got %0d", e.slot, slot);
                    errors++;
                end
                if (data !== e.data)
                begin
                    $error("data: expected %0h, got %0h", e.data, data);
                    errors++;
                end
                if (frame_end !== e.frame_end)
                begin
                    $error("frame_end: expected %0b, got %0b", e.frame_end, frame_end);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_req(logic o, logic [9:0] sc, logic [7:0] lv, logic l, logic r);
        dmx_req_t q;
        q.op = o; q.start_channel = sc; q.level = lv; q.last = l; q.ramp = r;
        pending_q.push_back(q);
    endtask

    task automatic add_ticks(int n);
        for (int i = 0; i < n; i++)
            add_req(OP_TICK, 10'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic write_cfg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_RAMP_MS)
            m_ramp_ms = val;
        else
            m_send_ivl = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !start && frame_bytes_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        wait (!busy);
        @(posedge clk);
    endtask

    // random mix: mostly well formed batches, ramped ones followed by ticks, some noise
    task automatic add_random(int n, int max_ticks);
        int len, pick;
        logic [9:0] sc;
        logic r;
        while (n > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 4);
                sc = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(33));
                r = 1'($urandom);
                for (int i = 0; i < len; i++)
                    add_req(OP_LEVEL, (i == 0) ? sc : 10'($urandom), 8'($urandom),
                            i == len - 1, r);
                n -= len;
                if (r)
                begin
                    len = $urandom_range(1, max_ticks);
                    add_ticks(len);
                    n -= len;
                end
            end
            else
            begin
                add_req(1'($urandom), 10'($urandom), 8'($urandom), 1'($urandom),
                        1'($urandom));
                n--;
            end
        end
    endtask

    initial begin
        m_now = '0; m_ramp_begin = '0; m_last_frame = '0; m_ramping = 1'b0;
        m_base = 0; m_count = 0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            m_cur[i] = '0; m_from[i] = '0; m_to[i] = '0; m_staged[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        write_cfg(CFG_RAMP_MS, 16'd3);
        write_cfg(CFG_SEND_IVL, 16'd0);
        add_ticks(1);
        add_req(OP_LEVEL, 10'd0, 8'hFF, 1'b1, 1'b0);
        add_req(OP_LEVEL, 10'd32, 8'hAA, 1'b1, 1'b0);
        add_req(OP_LEVEL, 10'd33, 8'h01, 1'b1, 1'b0);
        add_req(OP_LEVEL, 10'h3FF, 8'h55, 1'b1, 1'b1);
        add_req(OP_LEVEL, 10'd31, 8'h00, 1'b0, 1'b1);
        add_req(OP_LEVEL, 10'd5, 8'h7F, 1'b0, 1'b0);
        add_req(OP_LEVEL, 10'd9, 8'hFF, 1'b1, 1'b0);
        add_req(OP_LEVEL, 10'd1, 8'h00, 1'b1, 1'b1);
        add_ticks(1);
        add_req(OP_LEVEL, 10'd2, 8'hC3, 1'b1, 1'b1);
        add_ticks(4);
        add_req(OP_LEVEL, 10'd16, 8'h3C, 1'b1, 1'b1);
        add_ticks(2);
        drain();

        write_cfg(CFG_RAMP_MS, 16'd0);
        write_cfg(CFG_SEND_IVL, 16'hFFFF);
        add_req(OP_LEVEL, 10'd4, 8'h80, 1'b1, 1'b1);
        add_ticks(2);
        add_random(15, 2);
        drain();

        write_cfg(CFG_RAMP_MS, 16'd6);
        write_cfg(CFG_SEND_IVL, 16'd2);
        add_random(40, 8);
        drain();

        no_idle = 1;
        write_cfg(CFG_RAMP_MS, 16'hFFFF);
        write_cfg(CFG_SEND_IVL, 16'd1);
        add_random(20, 4);
        drain();
        no_idle = 0;

        write_cfg(CFG_RAMP_MS, 16'd1);
        write_cfg(CFG_SEND_IVL, 16'd0);
        add_random(20, 2);
        drain();

        write_cfg(CFG_RAMP_MS, RAMP_MS_RST);
        write_cfg(CFG_SEND_IVL, SEND_IVL_RST);
        add_random(25, 30);
        drain();

        $display("Covered %0d requests (batches, ticks, noise) over six register settings;",
                 n_requests);
        $display("checked %0d frame bytes in %0d frames, %0d mismatches.",
                 n_bytes, n_frames, errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
